// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the toy SPN block cipher.
// Each macro checks one property on the rising clock edge, off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: label");

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: label");

`endif

// File: src/tspn_pkg.sv
// Package for the toy SPN block cipher: S-boxes, bit permutations and round helpers.
// Used by the datapath, the configuration register and the top level; depends on nothing.
package tspn_pkg;

  localparam int KEY_W   = 24;
  localparam int BLOCK_W = 8;
  localparam int ROUNDS  = 4;

  typedef logic [BLOCK_W-1:0] block_t;
  typedef logic [KEY_W-1:0]   key_t;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  localparam logic [3:0] SBOX_FWD [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };
  localparam logic [3:0] SBOX_INV [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };
  localparam logic [2:0] PERM_FWD [8] = '{
    3'd0, 3'd3, 3'd4, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7
  };
  localparam logic [2:0] PERM_INV [8] = '{
    3'd0, 3'd6, 3'd4, 3'd1, 3'd2, 3'd5, 3'd3, 3'd7
  };

  // Configuration register indexes.
  localparam logic REG_CIPHER_KEY = 1'b0;

  // Round key r is the byte window starting at key bit 4r, counted from the MSB.
  function automatic block_t round_key(input key_t key, input int r);
    return key[(16 - 4 * r) +: 8];
  endfunction

  function automatic block_t subst_fwd(input block_t b);
    return {SBOX_FWD[b[7:4]], SBOX_FWD[b[3:0]]};
  endfunction

  function automatic block_t subst_inv(input block_t b);
    return {SBOX_INV[b[7:4]], SBOX_INV[b[3:0]]};
  endfunction

  // Block bit i (MSB first) moves to position p[i] (MSB first).
  function automatic block_t perm_fwd(input block_t b);
    block_t o;
    o = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[3'd7 - PERM_FWD[i]] = b[3'(7 - i)];
    end
    return o;
  endfunction

  function automatic block_t perm_inv(input block_t b);
    block_t o;
    o = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      o[3'd7 - PERM_INV[i]] = b[3'(7 - i)];
    end
    return o;
  endfunction

endpackage

// File: src/toy_spn_block_cipher_8bit.sv
// Top level of the toy 8-bit SPN block cipher: input register, cipher logic, result register.
// Depends on tspn_pkg, tspn_cfg, tspn_datapath and assert_macros.svh.
//
//   channel | direction | contents
//   in_     | slave     | tdata = block_in[7:0], tuser = kind
//   out_    | master    | tdata = block_out[7:0]
//   cfg_    | APB slave | register 0 at byte address 0: cipher_key[23:0]
//
// One word per cycle while out_tready stays high; a taken word passes the input register, then the result register.
// The input register and the result register form a two-entry pipeline around the rounds.
// Reset is synchronous and active low; it empties both stages and clears the key.
// When out_tready is low, the result holds and the input stage fills before in_tready drops.
`include "assert_macros.svh"

module toy_spn_block_cipher_8bit import tspn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] block_in
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] block_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  key_t   key;
  logic   s1_valid_r;
  logic   s1_op_r;
  block_t s1_block_r;
  logic   s2_valid_r;
  block_t s2_block_r;
  block_t result;
  logic   s2_ready;
  logic   in_take;

  tspn_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .key     (key)
  );

  tspn_datapath u_dp (
    .op        (s1_op_r),
    .block_in  (s1_block_r),
    .key       (key),
    .block_out (result)
  );

  assign s2_ready  = !s2_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;
  assign in_take   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_tuser;
      s1_block_r <= in_tdata;
    end
    if (s2_ready && s1_valid_r) begin
      s2_block_r <= result;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = s2_block_r;

  `ASSERT_ALWAYS(a_ready_when_out_empty, clk, rst_n, !s2_valid_r -> in_tready)
  `ASSERT_CLK(a_take_fills_s1, clk, rst_n, in_take |=> s1_valid_r)
  `ASSERT_CLK(a_s1_holds_on_stall, clk, rst_n,
    (s1_valid_r && !s2_ready) |=> (s1_valid_r && $stable(s1_block_r) && $stable(s1_op_r)))

endmodule

// File: src/tspn_cfg.sv
// APB-style configuration register holding the 24-bit cipher key.
// Depends on tspn_pkg for the key type and register index.
module tspn_cfg import tspn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output key_t        key
);

  key_t key_r;
  key_t key_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CIPHER_KEY);

  always_comb begin
    key_nxt = key_r;
    if (wr_en) begin
      key_nxt = pwdata[KEY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CIPHER_KEY) begin
      prdata = {{(32 - KEY_W){1'b0}}, key_r};
    end
  end

  assign key = key_r;

endmodule

// File: src/tspn_datapath.sv
// Combinational four-round encrypt and decrypt paths of the toy SPN cipher.
// Depends on tspn_pkg for the S-boxes, permutations and round key windows.
module tspn_datapath import tspn_pkg::*; (
  input  logic   op,
  input  block_t block_in,
  input  key_t   key,
  output block_t block_out
);

  block_t enc;
  block_t dec;

  always_comb begin
    enc = block_in;
    for (int r = 0; r < ROUNDS; r++) begin
      enc = subst_fwd(enc ^ round_key(key, r));
      if (r != ROUNDS - 1) begin
        enc = perm_fwd(enc);
      end
    end
    enc = enc ^ key[7:0];
  end

  always_comb begin
    dec = block_in ^ key[7:0];
    for (int r = ROUNDS - 1; r >= 0; r--) begin
      if (r != ROUNDS - 1) begin
        dec = perm_inv(dec);
      end
      dec = subst_inv(dec) ^ round_key(key, r);
    end
  end

  assign block_out = (op == OP_DECRYPT) ? dec : enc;

endmodule

// File: sim/toy_spn_block_cipher_8bit_tb.sv
// Self-checking testbench for the toy 8-bit SPN block cipher: directed and random words
// under several keys, with random idling on both stream sides. Depends on tspn_pkg and
// the toy_spn_block_cipher_8bit RTL.
module toy_spn_block_cipher_8bit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tspn_pkg::*;

  localparam int MAX_WAIT     = 19;
  localparam int RANDOM_WORDS = 94;
  localparam int KEY_PHASES   = 8;
  localparam logic [2:0] ADDR_KEY    = 3'd0;
  localparam logic [2:0] ADDR_UNUSED = 3'd4;

  localparam logic [3:0] FWD_BOX [16] = '{
    4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
    4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7
  };
  localparam logic [3:0] INV_BOX [16] = '{
    4'd14, 4'd3, 4'd4, 4'd8, 4'd1, 4'd12, 4'd10, 4'd15,
    4'd7, 4'd13, 4'd9, 4'd6, 4'd11, 4'd2, 4'd0, 4'd5
  };
  localparam logic [2:0] FWD_WIRE [8] = '{3'd0, 3'd3, 3'd4, 3'd6, 3'd2, 3'd5, 3'd1, 3'd7};
  localparam logic [2:0] INV_WIRE [8] = '{3'd0, 3'd6, 3'd4, 3'd1, 3'd2, 3'd5, 3'd3, 3'd7};

  typedef struct {
    op_t         kind;
    block_t      block_in;
    int unsigned gap;
  } cipher_word_t;

  typedef struct {
    op_t    kind;
    block_t block_in;
    block_t block_out;
  } cipher_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] block_in
  logic        in_tuser = 1'b0; // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] block_out
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cipher_word_t   pending_words[$];
  cipher_result_t expected_blocks[$];
  cipher_word_t   word_on_bus;
  key_t           key_model = '0;
  int unsigned    tx_gap_count = 0;
  int unsigned    rx_wait = 0;
  bit             tx_burst = 1'b0;
  bit             rx_burst = 1'b0;
  int unsigned    error_count = 0;
  int unsigned    words_checked = 0;
  int unsigned    encrypt_count = 0;
  int unsigned    decrypt_count = 0;
  int unsigned    keys_used = 1;

  toy_spn_block_cipher_8bit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic block_t sub_nibbles(input block_t b, input bit inverse);
    if (inverse) begin
      return {INV_BOX[b[7:4]], INV_BOX[b[3:0]]};
    end
    return {FWD_BOX[b[7:4]], FWD_BOX[b[3:0]]};
  endfunction

  // Bits are numbered from the MSB: bit i moves to position wire[i].
  function automatic block_t rewire(input block_t b, input bit inverse);
    block_t o;
    logic [2:0] dst;
    o = '0;
    for (int i = 0; i < 8; i++) begin
      dst = inverse ? INV_WIRE[i] : FWD_WIRE[i];
      o[7 - dst] = b[7 - i];
    end
    return o;
  endfunction

  function automatic block_t cipher_block(input op_t kind, input block_t b_in, input key_t key);
    block_t b;
    b = b_in;
    if (kind == OP_ENCRYPT) begin
      for (int r = 0; r < 4; r++) begin
        b = b ^ key[(16 - 4 * r) +: 8];
        b = sub_nibbles(b, 1'b0);
        if (r != 3) begin
          b = rewire(b, 1'b0);
        end
      end
      b = b ^ key[7:0];
    end else begin
      b = b ^ key[7:0];
      for (int r = 3; r >= 0; r--) begin
        if (r != 3) begin
          b = rewire(b, 1'b1);
        end
        b = sub_nibbles(b, 1'b1);
        b = b ^ key[(16 - 4 * r) +: 8];
      end
    end
    return b;
  endfunction

  function automatic int unsigned draw_wait(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic queue_word(input op_t kind, input block_t b);
    cipher_word_t w;
    w.kind = kind;
    w.block_in = b;
    w.gap = draw_wait(tx_burst);
    if ($urandom_range(0, 31) == 0) begin
      tx_burst = !tx_burst;
    end
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_blocks.size() != 0);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (addr == ADDR_KEY) begin
      key_model = data[KEY_W-1:0];
    end
  endtask

  task automatic cfg_read_check(input logic [2:0] addr);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    if (cfg_prdata[KEY_W-1:0] !== key_model) begin
      $display("%0t: key readback mismatch: expected %06h, actual %06h",
               $time, key_model, cfg_prdata[KEY_W-1:0]);
      error_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Driver: holds each word until taken, then waits out the next word's gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_blocks.push_back('{word_on_bus.kind, word_on_bus.block_in,
                                   cipher_block(word_on_bus.kind, word_on_bus.block_in,
                                                key_model)});
        if (word_on_bus.kind == OP_ENCRYPT) begin
          encrypt_count++;
        end else begin
          decrypt_count++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && tx_gap_count < pending_words[0].gap) begin
          tx_gap_count++;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          word_on_bus = pending_words.pop_front();
          tx_gap_count = 0;
          in_tdata <= word_on_bus.block_in;
          in_tuser <= word_on_bus.kind;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken word against the oldest expected block.
  always @(posedge clk) begin
    cipher_result_t exp_word;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual %02h", $time, out_tdata);
          error_count++;
        end else begin
          exp_word = expected_blocks.pop_front();
          words_checked++;
          if (out_tdata !== exp_word.block_out) begin
            $display("%0t: block_out mismatch (%s of %02h): expected %02h, actual %02h",
                     $time, exp_word.kind.name(), exp_word.block_in,
                     exp_word.block_out, out_tdata);
            error_count++;
          end
        end
        rx_wait = draw_wait(rx_burst);
        if ($urandom_range(0, 31) == 0) begin
          rx_burst = !rx_burst;
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    block_t edge_blocks [9];
    block_t plain;
    logic [31:0] key_value;
    edge_blocks = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h0F, 8'hF0, 8'hAA, 8'h55, 8'h3C};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The key comes out of reset as zero.
    cfg_read_check(ADDR_KEY);
    foreach (edge_blocks[i]) begin
      queue_word(OP_ENCRYPT, edge_blocks[i]);
      queue_word(OP_DECRYPT, edge_blocks[i]);
    end
    wait_drained();

    // Bits above the key width are dropped, and a write to an unused address is ignored.
    cfg_write(ADDR_KEY, 32'hFFFF_FFFF);
    cfg_read_check(ADDR_KEY);
    cfg_write(ADDR_UNUSED, 32'h0012_3456);
    cfg_read_check(ADDR_KEY);
    keys_used++;
    queue_word(OP_ENCRYPT, 8'h00);
    queue_word(OP_DECRYPT, 8'h00);
    queue_word(OP_ENCRYPT, 8'hFF);
    queue_word(OP_DECRYPT, 8'hFF);
    queue_word(OP_ENCRYPT, 8'h5A);
    queue_word(OP_DECRYPT, 8'h5A);
    wait_drained();

    for (int p = 0; p < KEY_PHASES; p++) begin
      case (p)
        0: begin
          key_value = 32'h0000_0000;
        end
        1: begin
          key_value = 32'h00FF_FFFF;
        end
        2: begin
          key_value = 32'h0000_0001;
        end
        3: begin
          key_value = 32'h0080_0000;
        end
        default: begin
          key_value = $urandom;
        end
      endcase
      cfg_write(ADDR_KEY, key_value);
      cfg_read_check(ADDR_KEY);
      keys_used++;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        plain = 8'($urandom_range(0, 255));
        // About one draw in four is a round trip: a block, then its ciphertext decrypted.
        if ($urandom_range(0, 3) == 0) begin
          queue_word(OP_ENCRYPT, plain);
          queue_word(OP_DECRYPT, cipher_block(OP_ENCRYPT, plain, key_value[KEY_W-1:0]));
          n++;
        end else begin
          queue_word(op_t'($urandom_range(0, 1)), plain);
        end
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d words (%0d encrypt, %0d decrypt) under %0d key settings.",
             words_checked, encrypt_count, decrypt_count, keys_used);
    $display("Both stream sides idled at random between 0 and %0d cycles per word.", MAX_WAIT);
    if (error_count == 0 && expected_blocks.size() == 0) begin
      $display("toy_spn_block_cipher_8bit_tb passed");
    end else begin
      $display("toy_spn_block_cipher_8bit_tb failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d words pending and %0d blocks expected",
             $time, pending_words.size(), expected_blocks.size());
    $display("toy_spn_block_cipher_8bit_tb failed");
    $finish;
  end

endmodule
